[sv/wrp_pkg.sv]
// Shared types, constants and helper functions for the WAV RIFF chunk parser.
// Used by wrp_parser, wrp_out_fifo and wav_riff_chunk_parser; depends on nothing.
package wrp_pkg;

    localparam int unsigned FifoDepth = 4;
    localparam int unsigned OutDataW  = 176;

    localparam logic [31:0] TagFmt  = 32'h666D_7420;
    localparam logic [31:0] TagData = 32'h6461_7461;

    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StNotRiff  = 3'd1;
    localparam logic [2:0] StFmtShort = 3'd2;
    localparam logic [2:0] StNoFmt    = 3'd3;
    localparam logic [2:0] StBadFmt   = 3'd4;
    localparam logic [2:0] StEmpty    = 3'd5;
    localparam logic [2:0] StTrunc    = 3'd6;

    typedef enum logic [6:0] {
        PhRiff = 7'b0000001,
        PhChdr = 7'b0000010,
        PhFmt  = 7'b0000100,
        PhSkip = 7'b0001000,
        PhPad  = 7'b0010000,
        PhData = 7'b0100000,
        PhDone = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] bytes_per_second;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
    } t_fmt;

    typedef struct packed {
        logic        pcm_vld;
        logic        rpt_vld;
        logic [7:0]  sample_byte;
        logic [2:0]  status;
        t_fmt        fmt;
        logic [31:0] data_length;
    } t_result;

    function automatic logic [7:0] riff_byte(input logic [3:0] idx);
        logic [7:0] v;
        unique case (idx)
            4'd0:       v = 8'h52;
            4'd1:       v = 8'h49;
            4'd2, 4'd3: v = 8'h46;
            4'd8:       v = 8'h57;
            4'd9:       v = 8'h41;
            4'd10:      v = 8'h56;
            4'd11:      v = 8'h45;
            default:    v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[sv/wrp_parser.sv]
// Byte-serial RIFF/WAVE parser: input register, chunk state and result forming.
// Depends on wrp_pkg for the phase type, tags, status codes and the result struct.
module wrp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_eof,
    output logic             o_busy,
    output logic             o_push,
    output wrp_pkg::t_result o_result
);
    import wrp_pkg::*;

    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             r_in_eof;

    t_phase           r_phase, n_phase;
    logic [3:0]       r_idx, n_idx;
    logic [31:0]      r_tag, n_tag;
    logic [31:0]      r_left, n_left;
    logic             r_odd, n_odd;
    logic             r_seen, n_seen;
    logic [15:0][7:0] r_fmt, n_fmt;
    logic [31:0]      r_dlen, n_dlen;

    logic             pcm_vld;
    logic             rpt_vld;
    logic [2:0]       rpt_status;
    logic             clear;
    logic [31:0]      left_dec;
    logic [31:0]      size_new;
    t_fmt             cur_fmt;
    t_fmt             nxt_fmt;

    always_comb begin
        cur_fmt = '{format_tag:       {r_fmt[1], r_fmt[0]},
                    channel_count:    {r_fmt[3], r_fmt[2]},
                    sample_rate:      {r_fmt[7], r_fmt[6], r_fmt[5], r_fmt[4]},
                    bytes_per_second: {r_fmt[11], r_fmt[10], r_fmt[9], r_fmt[8]},
                    block_align:      {r_fmt[13], r_fmt[12]},
                    bits_per_sample:  {r_fmt[15], r_fmt[14]}};
        nxt_fmt = '{format_tag:       {n_fmt[1], n_fmt[0]},
                    channel_count:    {n_fmt[3], n_fmt[2]},
                    sample_rate:      {n_fmt[7], n_fmt[6], n_fmt[5], n_fmt[4]},
                    bytes_per_second: {n_fmt[11], n_fmt[10], n_fmt[9], n_fmt[8]},
                    block_align:      {n_fmt[13], n_fmt[12]},
                    bits_per_sample:  {n_fmt[15], n_fmt[14]}};
    end

    always_comb begin
        left_dec = (r_left != 32'd0) ? r_left - 32'd1 : r_left;
        unique case (r_idx[1:0])
            2'd0:    size_new = {24'd0, r_in_byte};
            2'd1:    size_new = {r_left[31:16], r_in_byte, r_left[7:0]};
            2'd2:    size_new = {r_left[31:24], r_in_byte, r_left[15:0]};
            default: size_new = {r_in_byte, r_left[23:0]};
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_tag      = r_tag;
        n_left     = r_left;
        n_odd      = r_odd;
        n_seen     = r_seen;
        n_fmt      = r_fmt;
        n_dlen     = r_dlen;
        pcm_vld    = 1'b0;
        rpt_vld    = 1'b0;
        rpt_status = StOk;
        clear      = 1'b0;
        if (r_in_vld) begin
            unique case (r_phase)
                PhRiff: begin
                    if ((r_idx < 4'd4 || r_idx >= 4'd8) && r_in_byte != riff_byte(r_idx)) begin
                        rpt_vld    = 1'b1;
                        rpt_status = StNotRiff;
                        n_phase    = PhDone;
                    end else if (r_idx == 4'd11) begin
                        n_phase = PhChdr;
                        n_idx   = 4'd0;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PhChdr: begin
                    if (r_idx < 4'd4) begin
                        n_tag = {r_tag[23:0], r_in_byte};
                    end else begin
                        n_left = size_new;
                    end
                    if (r_idx == 4'd7) begin
                        n_idx = 4'd0;
                        n_odd = size_new[0];
                        if (r_tag == TagFmt) begin
                            if (size_new < 32'd16) begin
                                rpt_vld    = 1'b1;
                                rpt_status = StFmtShort;
                                n_phase    = PhDone;
                            end else begin
                                n_fmt   = '0;
                                n_phase = PhFmt;
                            end
                        end else if (r_tag == TagData) begin
                            n_dlen = size_new;
                            if (!r_seen) begin
                                rpt_vld    = 1'b1;
                                rpt_status = StNoFmt;
                                n_phase    = PhDone;
                            end else if (cur_fmt.format_tag != 16'd1 ||
                                         cur_fmt.channel_count == 16'd0 ||
                                         cur_fmt.sample_rate == 32'd0 ||
                                         cur_fmt.bits_per_sample == 16'd0) begin
                                rpt_vld    = 1'b1;
                                rpt_status = StBadFmt;
                                n_phase    = PhDone;
                            end else if (size_new == 32'd0) begin
                                rpt_vld    = 1'b1;
                                rpt_status = StEmpty;
                                n_phase    = PhDone;
                            end else begin
                                n_phase = PhData;
                            end
                        end else if (size_new == 32'd0) begin
                            n_phase = size_new[0] ? PhPad : PhChdr;
                        end else begin
                            n_phase = PhSkip;
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PhFmt: begin
                    n_fmt[r_idx] = r_in_byte;
                    n_left       = left_dec;
                    if (r_idx == 4'd15) begin
                        n_seen = 1'b1;
                        n_idx  = 4'd0;
                        if (left_dec == 32'd0) begin
                            n_phase = r_odd ? PhPad : PhChdr;
                        end else begin
                            n_phase = PhSkip;
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PhSkip: begin
                    n_left = left_dec;
                    if (left_dec == 32'd0) begin
                        n_phase = r_odd ? PhPad : PhChdr;
                        n_idx   = 4'd0;
                    end
                end
                PhPad: begin
                    n_phase = PhChdr;
                    n_idx   = 4'd0;
                end
                PhData: begin
                    pcm_vld = 1'b1;
                    n_left  = left_dec;
                    if (left_dec == 32'd0) begin
                        rpt_vld    = 1'b1;
                        rpt_status = StOk;
                        n_phase    = PhDone;
                    end
                end
                default: begin
                    n_phase = PhDone;
                end
            endcase
            if (r_in_eof) begin
                clear = 1'b1;
                if (n_phase != PhDone) begin
                    rpt_vld    = 1'b1;
                    rpt_status = StTrunc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_accept;
        end
        if (i_accept) begin
            r_in_byte <= i_byte;
            r_in_eof  <= i_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_phase <= PhRiff;
            r_idx   <= 4'd0;
            r_tag   <= 32'd0;
            r_left  <= 32'd0;
            r_odd   <= 1'b0;
            r_seen  <= 1'b0;
            r_fmt   <= '0;
            r_dlen  <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_tag   <= n_tag;
            r_left  <= n_left;
            r_odd   <= n_odd;
            r_seen  <= n_seen;
            r_fmt   <= n_fmt;
            r_dlen  <= n_dlen;
        end
    end

    assign o_busy = r_in_vld;
    assign o_push = pcm_vld || rpt_vld;

    always_comb begin
        o_result             = '0;
        o_result.pcm_vld     = pcm_vld;
        o_result.rpt_vld     = rpt_vld;
        o_result.sample_byte = r_in_byte;
        o_result.status      = rpt_status;
        o_result.fmt         = nxt_fmt;
        o_result.data_length = n_dlen;
    end

endmodule

[sv/wrp_out_fifo.sv]
// Output queue of parse results; each entry holds up to a PCM byte and a report.
// Depends on wrp_pkg for the result struct and the output word width.
module wrp_out_fifo #(
    parameter int unsigned DEPTH = wrp_pkg::FifoDepth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  wrp_pkg::t_result             i_result,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic                         o_is_report,
    output logic [wrp_pkg::OutDataW-1:0] o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import wrp_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH+1);

    t_result         r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            r_sub, n_sub;
    t_result         head;
    logic            fire;
    logic            last;
    logic            pop;

    assign head        = r_mem[r_rd_ptr];
    assign o_valid     = (r_count != '0);
    assign o_is_report = !(head.pcm_vld && !r_sub);
    assign fire        = o_valid && i_ready;
    assign last        = o_is_report || !head.rpt_vld;
    assign pop         = fire && last;

    always_comb begin
        if (o_is_report) begin
            o_data = {5'd0, head.data_length, head.fmt.bits_per_sample,
                      head.fmt.block_align, head.fmt.bytes_per_second,
                      head.fmt.sample_rate, head.fmt.channel_count,
                      head.fmt.format_tag, head.status, 8'd0};
        end else begin
            o_data = {{(OutDataW-8){1'b0}}, head.sample_byte};
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        n_sub    = r_sub;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH-1)) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH-1)) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (fire) begin
            n_sub = !last;
        end
        if (i_push && !pop) begin
            n_count = r_count + CntW'(1);
        end else if (!i_push && pop) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_sub    <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    assign o_count = r_count;

endmodule

[sv/wav_riff_chunk_parser.sv]
// Top level of the WAV RIFF chunk parser: input handshake, parser and result queue.
// Depends on wrp_pkg, wrp_parser and wrp_out_fifo.
//
// The slave stream takes a WAV file one byte per item, with tlast on the file's
// final byte. The master stream returns one item per PCM byte of the data chunk
// (tuser low) and one parse report per file (tuser high) that carries the status
// and the captured format fields. After an error the rest of the file is dropped.
// An accepted byte is registered, parsed in the next cycle and written to the
// result queue, whose head drives the master side. The block takes one byte per
// cycle while the queue has room; the last data byte yields a PCM item and then
// the report from one queue entry. The queue has DEPTH entries and the slave
// side stalls when the queue plus the byte in flight fill it. A stall on the
// master side fills the queue and then drops s_axis_tready; no item is lost.
// Synchronous reset returns the parser to the start of a file and empties the
// queue. After each tlast the parser starts a new file.
module wav_riff_chunk_parser #(
    parameter int unsigned DEPTH = wrp_pkg::FifoDepth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] in_byte
    input  logic                         s_axis_tlast,  // end_of_file
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] sample_byte, [10:8] status, [26:11] format_tag,
    // [42:27] channel_count, [74:43] sample_rate, [106:75] bytes_per_second,
    // [122:107] block_align, [138:123] bits_per_sample, [170:139] data_length
    output logic [wrp_pkg::OutDataW-1:0] m_axis_tdata,
    output logic                         m_axis_tuser   // is_report
);
    import wrp_pkg::*;

    localparam int unsigned CntW  = $clog2(DEPTH+1);
    localparam int unsigned CntW1 = CntW + 1;

    logic            accept;
    logic            busy;
    logic            push;
    t_result         result;
    logic [CntW-1:0] count;
    logic [CntW:0]   occupancy;

    assign occupancy     = {1'b0, count} + {{CntW{1'b0}}, busy};
    assign s_axis_tready = (occupancy < CntW1'(DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    wrp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_eof    (s_axis_tlast),
        .o_busy   (busy),
        .o_push   (push),
        .o_result (result)
    );

    wrp_out_fifo #(
        .DEPTH (DEPTH)
    ) u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (result),
        .i_ready     (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_is_report (m_axis_tuser),
        .o_data      (m_axis_tdata),
        .o_count     (count)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= CntW1'(DEPTH))
        else $error("result queue overflow");

    a_pcm_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[OutDataW-1:8] == '0))
        else $error("PCM item carries report fields");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (count < CntW'(DEPTH)) || (m_axis_tvalid && m_axis_tready))
        else $error("push into a full queue");
`endif

endmodule

[tb/sv/wav_riff_chunk_parser_test.sv]
// Self-checking testbench for wav_riff_chunk_parser: WAV files go in one byte per item.
// A behavioral parser in this file predicts every PCM item and report; depends on wrp_pkg.
// Directed header cases come first, then random well-formed, broken and truncated files.
module wav_riff_chunk_parser_test;
    import wrp_pkg::*;

    typedef struct packed {
        logic        is_report;
        logic [7:0]  sample_byte;
        logic [2:0]  status;
        t_fmt        fmt;
        logic [31:0] data_length;
    } t_wav_result;

    typedef struct packed {
        logic [7:0] value;
        logic       eof;
        logic       typed;
        logic [2:0] status;
    } t_stim_row;

    localparam int unsigned RandomItems = 1950;
    localparam logic [31:0] RiffWord = 32'h5249_4646;
    localparam logic [31:0] WaveWord = 32'h5741_5645;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = 8'h00;
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    // The rows with a typed status carry a report whose format fields are all still zero.
    t_stim_row directed_rows [27] = '{
        '{8'h58, 1'b1, 1'b1, StNotRiff},
        '{8'h52, 1'b1, 1'b1, StTrunc},
        '{8'h52, 1'b0, 1'b0, StOk}, '{8'h49, 1'b0, 1'b0, StOk},
        '{8'h46, 1'b0, 1'b0, StOk}, '{8'h46, 1'b0, 1'b0, StOk},
        '{8'hFF, 1'b0, 1'b0, StOk}, '{8'hFF, 1'b0, 1'b0, StOk},
        '{8'hFF, 1'b0, 1'b0, StOk}, '{8'hFF, 1'b0, 1'b0, StOk},
        '{8'h57, 1'b0, 1'b0, StOk}, '{8'h41, 1'b0, 1'b0, StOk},
        '{8'h56, 1'b0, 1'b0, StOk}, '{8'h45, 1'b0, 1'b0, StOk},
        '{8'h00, 1'b1, 1'b1, StTrunc},
        '{8'h52, 1'b0, 1'b0, StOk}, '{8'h49, 1'b0, 1'b0, StOk},
        '{8'h46, 1'b0, 1'b0, StOk}, '{8'h46, 1'b0, 1'b0, StOk},
        '{8'h00, 1'b0, 1'b0, StOk}, '{8'h00, 1'b0, 1'b0, StOk},
        '{8'h00, 1'b0, 1'b0, StOk}, '{8'h00, 1'b0, 1'b0, StOk},
        '{8'h57, 1'b0, 1'b0, StOk}, '{8'h41, 1'b0, 1'b0, StOk},
        '{8'h56, 1'b0, 1'b0, StOk},
        '{8'hFF, 1'b1, 1'b1, StNotRiff}
    };

    t_phase      prd_phase;
    logic [3:0]  prd_hdr_idx;
    logic [31:0] prd_tag;
    logic [31:0] prd_left;
    logic        prd_odd;
    logic        prd_fmt_seen;
    t_fmt        prd_fmt;
    logic [31:0] prd_data_len;

    t_wav_result step_out [$];
    t_wav_result wav_results_due [$];
    logic [7:0]  file_bytes [$];

    int unsigned error_count = 0;
    int unsigned live_count  = 0;
    int unsigned byte_count  = 0;
    int unsigned file_count  = 0;
    int unsigned pcm_count   = 0;
    int unsigned report_count = 0;
    int unsigned status_hist [8] = '{default: 0};
    int unsigned src_idle_pct  = 19;
    int unsigned sink_idle_pct = 84;

    wav_riff_chunk_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    function automatic void parser_clear();
        prd_phase    = PhRiff;
        prd_hdr_idx  = '0;
        prd_tag      = '0;
        prd_left     = '0;
        prd_odd      = 1'b0;
        prd_fmt_seen = 1'b0;
        prd_fmt      = '0;
        prd_data_len = '0;
    endfunction

    function automatic void emit_report(input logic [2:0] st);
        t_wav_result r;
        r             = '0;
        r.is_report   = 1'b1;
        r.status      = st;
        r.fmt         = prd_fmt;
        r.data_length = prd_data_len;
        step_out.push_back(r);
        prd_phase = PhDone;
    endfunction

    function automatic void end_chunk_if_empty();
        if (prd_left == 0) begin
            prd_phase   = prd_odd ? PhPad : PhChdr;
            prd_hdr_idx = '0;
        end
    endfunction

    // Predicts the results of one accepted byte into step_out; live is low for ignored bytes.
    function automatic void wav_parse_byte(input logic [7:0] b, input logic eof, output bit live);
        logic [3:0]  idx;
        logic [7:0]  magic;
        t_wav_result pcm;
        live = (prd_phase != PhDone);
        idx  = prd_hdr_idx;
        case (prd_phase)
            PhRiff: begin
                if (idx >= 12) idx = '0;
                magic = (idx < 4) ? RiffWord[8*(3-idx) +: 8] :
                        (idx >= 8) ? WaveWord[8*(11-idx) +: 8] : b;
                if (b != magic) begin
                    emit_report(StNotRiff);
                end else begin
                    idx = idx + 4'd1;
                    prd_hdr_idx = idx;
                    if (idx == 12) begin
                        prd_phase   = PhChdr;
                        prd_hdr_idx = '0;
                    end
                end
            end
            PhChdr: begin
                if (idx >= 8) idx = '0;
                if (idx < 4) prd_tag = {prd_tag[23:0], b};
                else if (idx == 4) prd_left = {24'd0, b};
                else prd_left[8*(idx-4) +: 8] = b;
                idx = idx + 4'd1;
                prd_hdr_idx = idx;
                if (idx == 8) begin
                    prd_hdr_idx = '0;
                    prd_odd     = prd_left[0];
                    if (prd_tag == TagFmt) begin
                        if (prd_left < 16) begin
                            emit_report(StFmtShort);
                        end else begin
                            prd_fmt   = '0;
                            prd_phase = PhFmt;
                        end
                    end else if (prd_tag == TagData) begin
                        prd_data_len = prd_left;
                        if (!prd_fmt_seen) emit_report(StNoFmt);
                        else if (prd_fmt.format_tag != 16'd1 || prd_fmt.channel_count == 0 ||
                                 prd_fmt.sample_rate == 0 || prd_fmt.bits_per_sample == 0)
                            emit_report(StBadFmt);
                        else if (prd_left == 0) emit_report(StEmpty);
                        else prd_phase = PhData;
                    end else begin
                        prd_phase = PhSkip;
                        end_chunk_if_empty();
                    end
                end
            end
            PhFmt: begin
                if (idx < 2) prd_fmt.format_tag[8*idx +: 8] = b;
                else if (idx < 4) prd_fmt.channel_count[8*(idx-2) +: 8] = b;
                else if (idx < 8) prd_fmt.sample_rate[8*(idx-4) +: 8] = b;
                else if (idx < 12) prd_fmt.bytes_per_second[8*(idx-8) +: 8] = b;
                else if (idx < 14) prd_fmt.block_align[8*(idx-12) +: 8] = b;
                else prd_fmt.bits_per_sample[8*(idx-14) +: 8] = b;
                if (prd_left != 0) prd_left = prd_left - 32'd1;
                if (idx == 15) begin
                    prd_fmt_seen = 1'b1;
                    prd_phase    = PhSkip;
                    prd_hdr_idx  = '0;
                    end_chunk_if_empty();
                end else begin
                    prd_hdr_idx = idx + 4'd1;
                end
            end
            PhSkip: begin
                if (prd_left != 0) prd_left = prd_left - 32'd1;
                end_chunk_if_empty();
            end
            PhPad: begin
                prd_phase   = PhChdr;
                prd_hdr_idx = '0;
            end
            PhData: begin
                pcm             = '0;
                pcm.sample_byte = b;
                step_out.push_back(pcm);
                if (prd_left != 0) prd_left = prd_left - 32'd1;
                if (prd_left == 0) emit_report(StOk);
            end
            default: prd_phase = PhDone;
        endcase
        if (eof) begin
            if (prd_phase != PhDone) emit_report(StTrunc);
            parser_clear();
        end
    endfunction

    function automatic void put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_tag(input logic [31:0] t);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(t[8*i +: 8]);
    endfunction

    function automatic void put_random(input int unsigned n);
        repeat (n) file_bytes.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void put_other_chunk();
        int unsigned sz;
        sz = $urandom_range(0, 9);
        put_tag($urandom);
        put_le(sz, 4);
        put_random(sz + sz % 2);
    endfunction

    function automatic void put_fmt_chunk();
        t_fmt        f;
        int unsigned sz;
        sz = ($urandom_range(99) < 6) ? $urandom_range(0, 15) : $urandom_range(16, 22);
        f.format_tag       = ($urandom_range(99) < 85) ? 16'd1 : 16'($urandom);
        f.channel_count    = ($urandom_range(99) < 8) ? 16'd0 :
                             ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(1, 8));
        f.sample_rate      = ($urandom_range(99) < 8) ? 32'd0 : $urandom;
        f.bytes_per_second = $urandom;
        f.block_align      = 16'($urandom);
        f.bits_per_sample  = ($urandom_range(99) < 8) ? 16'd0 : 16'($urandom);
        if ($urandom_range(99) < 5) begin
            f            = '1;
            f.format_tag = 16'd1;
        end
        put_tag(TagFmt);
        put_le(sz, 4);
        if (sz < 16) begin
            put_random(sz + sz % 2);
        end else begin
            put_le(32'(f.format_tag), 2);
            put_le(32'(f.channel_count), 2);
            put_le(f.sample_rate, 4);
            put_le(f.bytes_per_second, 4);
            put_le(32'(f.block_align), 2);
            put_le(32'(f.bits_per_sample), 2);
            put_random(sz - 16 + sz % 2);
        end
    endfunction

    // Builds one file into file_bytes: mostly well-formed, sometimes broken, cut short or noise.
    function automatic void build_random_file();
        int unsigned roll;
        int unsigned pos;
        int unsigned keep;
        logic [31:0] sz;
        file_bytes.delete();
        if ($urandom_range(99) < 5) begin
            put_random($urandom_range(1, 20));
            return;
        end
        put_tag(RiffWord);
        put_le($urandom, 4);
        put_tag(WaveWord);
        if ($urandom_range(99) < 4) begin
            pos = $urandom_range(0, 7);
            if (pos >= 4) pos = pos + 4;
            file_bytes[pos] = 8'($urandom_range(255));
        end
        repeat ($urandom_range(0, 2)) put_other_chunk();
        if ($urandom_range(99) < 88) begin
            put_fmt_chunk();
            if ($urandom_range(99) < 15) begin
                if ($urandom_range(1) == 1) put_other_chunk();
                put_fmt_chunk();
            end
        end
        if ($urandom_range(99) < 30) put_other_chunk();
        roll = $urandom_range(99);
        if (roll < 5) sz = 32'd0;
        else if (roll < 10) sz = $urandom | 32'h0100_0000;
        else if (roll < 13) sz = $urandom_range(200, 400);
        else sz = $urandom_range(1, 16);
        put_tag(TagData);
        put_le(sz, 4);
        if (sz > 400) begin
            put_random($urandom_range(0, 30));
        end else begin
            put_random(sz + sz[0]);
            if ($urandom_range(99) < 25) put_random($urandom_range(1, 4));
        end
        if ($urandom_range(99) < 10) begin
            keep = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > keep) void'(file_bytes.pop_back());
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eof, input logic typed,
                             input logic [2:0] typed_status);
        t_wav_result want;
        bit          live;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        do @(posedge i_clk); while (!s_axis_tready);
        step_out.delete();
        wav_parse_byte(b, eof, live);
        if (typed) begin
            want           = '0;
            want.is_report = 1'b1;
            want.status    = typed_status;
            wav_results_due.push_back(want);
        end else begin
            foreach (step_out[i]) wav_results_due.push_back(step_out[i]);
        end
        byte_count++;
        if (live) live_count++;
    endtask

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic check_result();
        t_wav_result got;
        t_wav_result want;
        got.is_report            = m_axis_tuser;
        got.sample_byte          = m_axis_tdata[7:0];
        got.status               = m_axis_tdata[10:8];
        got.fmt.format_tag       = m_axis_tdata[26:11];
        got.fmt.channel_count    = m_axis_tdata[42:27];
        got.fmt.sample_rate      = m_axis_tdata[74:43];
        got.fmt.bytes_per_second = m_axis_tdata[106:75];
        got.fmt.block_align      = m_axis_tdata[122:107];
        got.fmt.bits_per_sample  = m_axis_tdata[138:123];
        got.data_length          = m_axis_tdata[170:139];
        if (wav_results_due.size() == 0) begin
            $error("Unexpected output item: is_report %0b, tdata 0x%0h", got.is_report,
                   m_axis_tdata);
            error_count++;
            return;
        end
        want = wav_results_due.pop_front();
        cmp_field("is_report", 32'(want.is_report), 32'(got.is_report));
        cmp_field("sample_byte", 32'(want.sample_byte), 32'(got.sample_byte));
        cmp_field("status", 32'(want.status), 32'(got.status));
        cmp_field("format_tag", 32'(want.fmt.format_tag), 32'(got.fmt.format_tag));
        cmp_field("channel_count", 32'(want.fmt.channel_count), 32'(got.fmt.channel_count));
        cmp_field("sample_rate", want.fmt.sample_rate, got.fmt.sample_rate);
        cmp_field("bytes_per_second", want.fmt.bytes_per_second, got.fmt.bytes_per_second);
        cmp_field("block_align", 32'(want.fmt.block_align), 32'(got.fmt.block_align));
        cmp_field("bits_per_sample", 32'(want.fmt.bits_per_sample),
                  32'(got.fmt.bits_per_sample));
        cmp_field("data_length", want.data_length, got.data_length);
        if (want.is_report) begin
            report_count++;
            status_hist[want.status]++;
        end else begin
            pcm_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result();
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    initial begin
        parser_clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[i])
            send_byte(directed_rows[i].value, directed_rows[i].eof, directed_rows[i].typed,
                      directed_rows[i].status);
        live_count = 0;
        while (live_count < RandomItems) begin
            if (live_count < RandomItems / 3) begin
                src_idle_pct  = 19;
                sink_idle_pct = 84;
            end else if (live_count < 2 * RandomItems / 3) begin
                src_idle_pct  = 84;
                sink_idle_pct = 19;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            build_random_file();
            foreach (file_bytes[i])
                send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, StOk);
            file_count++;
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (wav_results_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Ran %0d files and the header cases: %0d bytes, %0d PCM items, %0d reports.",
                 file_count, byte_count, pcm_count, report_count);
        $display("Reports by status (ok..truncated): %0d %0d %0d %0d %0d %0d %0d",
                 status_hist[0], status_hist[1], status_hist[2], status_hist[3],
                 status_hist[4], status_hist[5], status_hist[6]);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d output items still expected.", wav_results_due.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
